// ===== rtl/core/erdo_pkg.sv =====
package erdo_pkg;

    // Default ring size
    localparam int unsigned RING_DEPTH_DEF = 32;

    // Field widths
    localparam int unsigned OP_W   = 2;
    localparam int unsigned KIND_W = 8;
    localparam int unsigned ARG_W  = 32;

    // Input word: op, kind, arg_a, arg_b, arg_c, padded to whole bytes
    localparam int unsigned IN_BITS = OP_W + KIND_W + 3 * ARG_W;
    localparam int unsigned IN_W    = ((IN_BITS + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // One stored event record
    typedef struct packed {
        logic signed [ARG_W-1:0] arg_c;
        logic signed [ARG_W-1:0] arg_b;
        logic signed [ARG_W-1:0] arg_a;
        logic [KIND_W-1:0]       kind;
    } event_t;

    // Per-cell control from the ring controller
    typedef struct packed {
        logic load;   // take the pushed event
        logic shift;  // take the event of the next younger cell
    } cell_ctrl_t;

endpackage

// ===== rtl/core/erdo_cell.sv =====
module erdo_cell (
    input  logic                clk,
    input  erdo_pkg::cell_ctrl_t ctrl,
    input  erdo_pkg::event_t    push_ev,
    input  erdo_pkg::event_t    upper_ev,
    output erdo_pkg::event_t    ev
);
    import erdo_pkg::*;

    event_t ev_reg;
    event_t ev_next;

    // Load a new event, take the younger neighbour's event, or hold
    always_comb
    begin
        ev_next = ev_reg;
        if (ctrl.load)
        begin
            ev_next = push_ev;
        end
        else if (ctrl.shift)
        begin
            ev_next = upper_ev;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg <= ev_next;
    end

    assign ev = ev_reg;

endmodule

// ===== rtl/core/event_ring_drop_oldest.sv =====
// Channel  Dir  tdata fields (lowest bit first)                                  Width
// s_*      in   op[1:0] push_kind[9:2] push_arg_a[41:10] push_arg_b[73:42]       112
//               push_arg_c[105:74], zero pad
// m_*      out  found[0] dropped[1] ev_kind[9:2] ev_arg_a[41:10] ev_arg_b[73:42]  112 at
//               ev_arg_c[105:74] fill_count (CNT_W bits from 106), zero pad       depth 32
//
// One word is taken per cycle; its result appears in the output register on the
// next cycle. The whole cell row is updated at once for each word taken (cell 0
// always holds the oldest event, a pop shifts the whole row down by one).
// rst_n clears the fill count and the output valid; the cells hold no reset.
// The input stalls only while a result waits in the output register and m_tready is low.
module event_ring_drop_oldest #(
    parameter int unsigned RING_DEPTH = erdo_pkg::RING_DEPTH_DEF,
    localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1),
    localparam int unsigned OUT_BITS = 2 + erdo_pkg::KIND_W + 3 * erdo_pkg::ARG_W + CNT_W,
    localparam int unsigned OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // op, push_kind, push_arg_a, push_arg_b, push_arg_c, zero pad
    input  logic [erdo_pkg::IN_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // found, dropped, ev_kind, ev_arg_a, ev_arg_b, ev_arg_c, fill_count, zero pad
    output logic [OUT_W-1:0]          m_tdata
);
    import erdo_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

    logic [OP_W-1:0]  op;
    event_t           push_ev;
    logic             accept;
    logic             full;
    logic             empty;
    logic             do_push;
    logic             do_pop;
    logic             do_clear;
    logic             shift_row;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    cell_ctrl_t       ctrl   [RING_DEPTH];
    event_t           cell_q [RING_DEPTH];
    event_t           upper  [RING_DEPTH];

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             found_reg;
    logic             dropped_reg;
    event_t           ev_reg;
    logic [CNT_W-1:0] fill_reg;

    // Unpack the input word
    assign op              = s_tdata[OP_W-1:0];
    assign push_ev.kind    = s_tdata[OP_W +: KIND_W];
    assign push_ev.arg_a   = s_tdata[OP_W + KIND_W +: ARG_W];
    assign push_ev.arg_b   = s_tdata[OP_W + KIND_W + ARG_W +: ARG_W];
    assign push_ev.arg_c   = s_tdata[OP_W + KIND_W + 2 * ARG_W +: ARG_W];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);

    // Decode the operation
    always_comb
    begin
        do_push  = 1'b0;
        do_pop   = 1'b0;
        do_clear = 1'b0;
        unique case (op)
            OP_PUSH:  do_push  = accept;
            OP_POP:   do_pop   = accept && !empty;
            OP_CLEAR: do_clear = accept;
            default:  ;
        endcase
    end

    // A pop, or a push into a full ring, moves every event one cell towards the head
    assign shift_row = do_pop || (do_push && full);

    // Next fill count
    always_comb
    begin
        count_next = count_reg;
        if (do_clear)
        begin
            count_next = '0;
        end
        else if (do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (do_push && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Row of cells: cell 0 is the oldest event
    for (genvar i = 0; i < RING_DEPTH; i++)
    begin : g_cell
        if (i == RING_DEPTH - 1)
        begin : g_last
            assign upper[i] = push_ev;
            assign ctrl[i].load = do_push && (full || (count_reg == CNT_W'(i)));
        end
        else
        begin : g_mid
            assign upper[i] = cell_q[i + 1];
            assign ctrl[i].load = do_push && !full && (count_reg == CNT_W'(i));
        end
        assign ctrl[i].shift = shift_row;

        erdo_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl[i]),
            .push_ev  (push_ev),
            .upper_ev (upper[i]),
            .ev       (cell_q[i])
        );
    end

    // Hold a result until the sink takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg   <= do_pop;
            dropped_reg <= do_push && full;
            ev_reg      <= do_pop ? cell_q[0] : '0;
            fill_reg    <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({fill_reg, ev_reg.arg_c, ev_reg.arg_b, ev_reg.arg_a,
                              ev_reg.kind, dropped_reg, found_reg});

endmodule
